>>> hw/rtl/itoa_pkg.sv
`default_nettype none

package itoa_pkg;

   localparam int VALUE_BITS_DFLT = 32;

   // format selector codes
   typedef enum logic [2:0] {
      OP_BIN      = 3'd0,
      OP_BIN_PAD  = 3'd1,
      OP_HEX_LC   = 3'd2,
      OP_HEX_UC   = 3'd3,
      OP_HEX_LC_P = 3'd4,
      OP_HEX_UC_P = 3'd5,
      OP_UDEC     = 3'd6,
      OP_SDEC     = 3'd7
   } op_type;

   localparam logic [6:0] CH_ZERO  = 7'h30;
   localparam logic [6:0] CH_MINUS = 7'h2D;
   localparam logic [6:0] CH_LA    = 7'h61;
   localparam logic [6:0] CH_UA    = 7'h41;

   // controller to datapath
   typedef struct packed {
      logic load;        // take a new value
      logic conv;        // one shift-add-3 step
      logic dload;       // move BCD digits into the output shifter
      logic shift;       // drop one leading zero digit
      logic emit_sign;   // send '-'
      logic emit_digit;  // send the top digit
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_dec;
      logic pad;
      logic neg;
      logic top_zero;
      logic rem_one;
      logic slot_free;
   } sts_type;

   // decimal digits of 2^vb - 1 (log10(2) ~ 1233/4096, exact over 8..64)
   function automatic int dec_digits(int vb);
      return ((vb * 1233) >> 12) + 1;
   endfunction

   function automatic int hex_digits(int vb);
      return (vb + 3) >> 2;
   endfunction

   function automatic logic [6:0] hex_char(logic [3:0] nib, logic upper);
      logic [6:0] base;
      base = upper ? CH_UA : CH_LA;
      if (nib < 4'd10) begin
         return CH_ZERO + {3'b000, nib};
      end
      return base + {3'b000, nib} - 7'd10;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/itoa_req_if.sv
`default_nettype none

interface itoa_req_if
   import itoa_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DFLT
);
   logic                  valid;
   logic                  ready;
   logic [2:0]            op;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/itoa_rsp_if.sv
`default_nettype none

interface itoa_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] ch;
   logic       last;

   modport source (output valid, output ch, output last, input ready);
   modport sink   (input valid, input ch, input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/integer_to_ascii_formatter_top.sv
`default_nettype none

// Integer to ASCII formatter. Each req_chan transfer carries a format code (op) and a
// VALUE_BITS-wide value; the block answers with one rsp_chan transfer per ASCII character,
// most significant first, with last set on the final character. Formats: binary with
// leading zeros dropped, binary padded to VALUE_BITS digits, hex lower/upper case, either
// unpadded or padded to ceil(VALUE_BITS/4) digits, unsigned decimal, and signed decimal
// with a leading '-'. Zero gives "0" in the unpadded formats. The block works on one value
// at a time and sends one character per cycle while the output register is free. Dropped
// leading zeros are shifted out in the skip state. Decimal values first pass through the binary
// to BCD conversion, a shift-add-3 register of one digit per decimal position (10 at 32 bits)
// that consumes one value bit a cycle. A full output register holds back the sign and digits
// until the sink takes the waiting character. A character left waiting in the output
// register does not block the next value.

module integer_to_ascii_formatter_top
   import itoa_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DFLT
)(
   input  wire logic  clock,
   input  wire logic  reset,
   itoa_req_if.sink   req_chan,
   itoa_rsp_if.source rsp_chan
);

   cmd_type cmd;
   sts_type sts;
   logic    req_ready;

   // controller sequences load, conversion, sign, zero skip and character output
   itoa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts_i     (sts),
      .cmd_o     (cmd)
   );

   assign req_chan.ready = req_ready;

   // datapath holds the value, BCD digits, output shifter and output register
   itoa_dpath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .op_i     (req_chan.op),
      .value_i  (req_chan.value),
      .cmd_i    (cmd),
      .sts_o    (sts),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

>>> hw/rtl/itoa_ctrl.sv
`default_nettype none

module itoa_ctrl
   import itoa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire sts_type sts_i,
   output cmd_type      cmd_o
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CONV  = 6'b000010,
      ST_DLOAD = 6'b000100,
      ST_SIGN  = 6'b001000,
      ST_SKIP  = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd_o     = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_o.load = 1'b1;
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            if (!sts_i.is_dec) begin
               state_in = ST_SKIP;
            end else begin
               cmd_o.conv = 1'b1;
               if (sts_i.rem_one) begin
                  state_in = ST_DLOAD;
               end
            end
         end
         ST_DLOAD: begin
            cmd_o.dload = 1'b1;
            state_in    = sts_i.neg ? ST_SIGN : ST_SKIP;
         end
         ST_SIGN: begin
            if (sts_i.slot_free) begin
               cmd_o.emit_sign = 1'b1;
               state_in        = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (!sts_i.pad && sts_i.top_zero && !sts_i.rem_one) begin
               cmd_o.shift = 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts_i.slot_free) begin
               cmd_o.emit_digit = 1'b1;
               if (sts_i.rem_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_emit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd_o.emit_digit || cmd_o.emit_sign) |-> sts_i.slot_free)
      else $error("character sent while output register is occupied");

   a_sign_only_neg: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SIGN) |-> (sts_i.neg && sts_i.is_dec))
      else $error("sign state entered for a non-negative value");

   a_no_skip_padded: assert property (@(posedge clock) disable iff (reset)
      cmd_o.shift |-> !sts_i.pad)
      else $error("leading digit dropped in a padded format");

endmodule

`default_nettype wire

>>> hw/rtl/itoa_dpath.sv
`default_nettype none

module itoa_dpath
   import itoa_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DFLT
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [2:0]            op_i,
   input  wire logic [VALUE_BITS-1:0] value_i,
   input  wire cmd_type               cmd_i,
   output sts_type                    sts_o,
   itoa_rsp_if.source                 rsp_chan
);

   localparam int DEC_DIGITS = dec_digits(VALUE_BITS);
   localparam int HEX_DIGITS = hex_digits(VALUE_BITS);
   localparam int DIG_W      = 4 * DEC_DIGITS;
   // decimal needs the most room; binary and hex align to its top
   localparam int SH_W       = DIG_W;
   localparam int RW         = $clog2(VALUE_BITS + 1);

   op_type                op_ff;
   logic                  neg_ff, neg_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [DIG_W-1:0]      bcd_ff, bcd_in, bcd_adj;
   logic [SH_W-1:0]       sh_ff, sh_in, sh_shifted;
   logic [RW-1:0]         rem_ff, rem_in;
   logic                  valid_ff, valid_in;
   logic [6:0]            ch_ff, ch_in;
   logic                  last_ff, last_in;

   logic                  is_bin, is_dec, pad, upper;
   logic                  ld_bin, ld_dec;
   logic [3:0]            top_nib;
   logic [6:0]            digit_ch;

   assign is_bin  = (op_ff == OP_BIN) || (op_ff == OP_BIN_PAD);
   assign is_dec  = (op_ff == OP_UDEC) || (op_ff == OP_SDEC);
   assign pad     = (op_ff == OP_BIN_PAD) || (op_ff == OP_HEX_LC_P) || (op_ff == OP_HEX_UC_P);
   assign upper   = (op_ff == OP_HEX_UC) || (op_ff == OP_HEX_UC_P);
   assign ld_bin  = (op_type'(op_i) == OP_BIN) || (op_type'(op_i) == OP_BIN_PAD);
   assign ld_dec  = (op_type'(op_i) == OP_UDEC) || (op_type'(op_i) == OP_SDEC);
   assign top_nib = sh_ff[SH_W-1 -: 4];

   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         bcd_adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                       : bcd_ff[i*4 +: 4];
      end
   end

   assign sh_shifted = is_bin ? (sh_ff << 1) : (sh_ff << 4);

   always_comb begin
      if (is_bin) begin
         digit_ch = CH_ZERO + {6'b000000, sh_ff[SH_W-1]};
      end else if (is_dec) begin
         digit_ch = CH_ZERO + {3'b000, top_nib};
      end else begin
         digit_ch = hex_char(top_nib, upper);
      end
   end

   always_comb begin
      neg_in = neg_ff;
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      sh_in  = sh_ff;
      rem_in = rem_ff;
      if (cmd_i.load) begin
         neg_in = (op_type'(op_i) == OP_SDEC) && value_i[VALUE_BITS-1];
         mag_in = neg_in ? (~value_i + 1'b1) : value_i;
         bcd_in = '0;
         if (ld_bin) begin
            sh_in  = SH_W'(value_i) << (SH_W - VALUE_BITS);
            rem_in = RW'(VALUE_BITS);
         end else if (ld_dec) begin
            sh_in  = '0;
            rem_in = RW'(VALUE_BITS);
         end else begin
            sh_in  = SH_W'(value_i) << (SH_W - 4 * HEX_DIGITS);
            rem_in = RW'(HEX_DIGITS);
         end
      end else if (cmd_i.conv) begin
         bcd_in = {bcd_adj[DIG_W-2:0], mag_ff[VALUE_BITS-1]};
         mag_in = mag_ff << 1;
         rem_in = rem_ff - 1'b1;
      end else if (cmd_i.dload) begin
         sh_in  = bcd_ff;
         rem_in = RW'(DEC_DIGITS);
      end else if (cmd_i.shift || cmd_i.emit_digit) begin
         sh_in  = sh_shifted;
         rem_in = rem_ff - 1'b1;
      end
   end

   // output register: hold until the sink takes it
   always_comb begin
      valid_in = valid_ff && !rsp_chan.ready;
      ch_in    = ch_ff;
      last_in  = last_ff;
      if (cmd_i.emit_sign) begin
         valid_in = 1'b1;
         ch_in    = CH_MINUS;
         last_in  = 1'b0;
      end else if (cmd_i.emit_digit) begin
         valid_in = 1'b1;
         ch_in    = digit_ch;
         last_in  = (rem_ff == RW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.load) begin
         op_ff <= op_type'(op_i);
      end
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      bcd_ff  <= bcd_in;
      sh_ff   <= sh_in;
      rem_ff  <= rem_in;
      ch_ff   <= ch_in;
      last_ff <= last_in;
   end

   assign sts_o.is_dec    = is_dec;
   assign sts_o.pad       = pad;
   assign sts_o.neg       = neg_ff;
   assign sts_o.top_zero  = is_bin ? !sh_ff[SH_W-1] : (top_nib == 4'd0);
   assign sts_o.rem_one   = (rem_ff == RW'(1));
   assign sts_o.slot_free = !valid_ff || rsp_chan.ready;

   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.ch    = ch_ff;
   assign rsp_chan.last  = last_ff;

   a_emit_has_digit: assert property (@(posedge clock) disable iff (reset)
      (cmd_i.emit_digit || cmd_i.shift) |-> (rem_ff != '0))
      else $error("digit taken with no digits left");

   a_conv_dec_only: assert property (@(posedge clock) disable iff (reset)
      (cmd_i.conv || cmd_i.dload) |-> is_dec)
      else $error("decimal conversion run for a non-decimal format");

   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> !(last_ff && (ch_ff == CH_MINUS)))
      else $error("text ends on a minus sign");

endmodule

`default_nettype wire

>>> bench/integer_to_ascii_formatter_top_tb.sv
`default_nettype none

module integer_to_ascii_formatter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import itoa_pkg::*;

   localparam int VALUE_BITS  = 32;
   localparam int RAND_VALUES = 480;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 400;
   localparam int TAIL_CYCLES = 100;

   // one character of formatted text as it leaves the block
   typedef struct packed {
      logic [6:0] ch;
      logic       last;
   } text_char_t;

   // Keeps the characters still owed by the block, oldest first, and
   // compares every delivered character against them.
   class text_scoreboard;
      localparam logic [6:0] ASCII_ZERO    = 7'h30;
      localparam logic [6:0] ASCII_ONE     = 7'h31;
      localparam logic [6:0] ASCII_MINUS   = 7'h2D;
      localparam logic [6:0] ASCII_LOWER_A = 7'h61;
      localparam logic [6:0] ASCII_UPPER_A = 7'h41;

      text_char_t pending_text[$];
      int         failures;
      int         chars_seen;

      // Format one accepted value and queue its characters.
      function void predict_text(op_type op, logic [31:0] v);
         logic [6:0] text[$];
         logic [6:0] rev_digits[$];
         logic [31:0] mag;
         logic [3:0]  nib;
         int          top;
         int          i;
         bit          upper;
         text_char_t  c;
         case (op)
            OP_BIN, OP_BIN_PAD: begin
               top = VALUE_BITS - 1;
               if (op == OP_BIN)
                  while (top > 0 && !v[top]) top--;
               for (i = top; i >= 0; i--)
                  text.push_back(v[i] ? ASCII_ONE : ASCII_ZERO);
            end
            OP_HEX_LC, OP_HEX_UC, OP_HEX_LC_P, OP_HEX_UC_P: begin
               upper = (op == OP_HEX_UC) || (op == OP_HEX_UC_P);
               top = VALUE_BITS / 4 - 1;
               if (op == OP_HEX_LC || op == OP_HEX_UC)
                  while (top > 0 && v[4*top +: 4] == 4'h0) top--;
               for (i = top; i >= 0; i--) begin
                  nib = v[4*i +: 4];
                  if (nib < 4'd10)
                     text.push_back(ASCII_ZERO + 7'(nib));
                  else
                     text.push_back((upper ? ASCII_UPPER_A : ASCII_LOWER_A)
                                    + 7'(nib - 4'd10));
               end
            end
            default: begin
               mag = v;
               if (op == OP_SDEC && v[VALUE_BITS-1]) begin
                  text.push_back(ASCII_MINUS);
                  mag = ~v + 32'd1;
               end
               do begin
                  rev_digits.push_back(ASCII_ZERO + 7'(mag % 32'd10));
                  mag = mag / 32'd10;
               end while (mag != 32'd0);
               while (rev_digits.size() > 0)
                  text.push_back(rev_digits.pop_back());
            end
         endcase
         for (i = 0; i < text.size(); i++) begin
            c.ch   = text[i];
            c.last = (i == text.size() - 1);
            pending_text.push_back(c);
         end
      endfunction

      function void check_char(logic [6:0] ch, logic last);
         text_char_t want;
         chars_seen++;
         if (pending_text.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("char %0d: unexpected ch=%02h last=%0d with nothing pending",
                        chars_seen, ch, last);
            return;
         end
         want = pending_text.pop_front();
         if (ch !== want.ch || last !== want.last) begin
            failures++;
            if (failures <= 10)
               $display("char %0d: expected ch=%02h last=%0d, got ch=%02h last=%0d",
                        chars_seen, want.ch, want.last, ch, last);
         end
      endfunction

      function int pending_count();
         return pending_text.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   itoa_req_if #(.VALUE_BITS(VALUE_BITS)) req_chan ();
   itoa_rsp_if rsp_chan ();

   integer_to_ascii_formatter_top #(
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   text_scoreboard sb = new();

   // sender pacing: items per burst left, largest gap between bursts
   int burst_left  = 0;
   int gap_max     = 4;
   // cycles the receiver must hold off, picked up by the receiver process
   int hold_cycles = 0;
   int cycle_count = 0;

   // 8 ns clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Check every character transfer at the rising edge. All DUT outputs and
   // TB drives settle away from this edge, so sampled values are stable.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_char(rsp_chan.ch, rsp_chan.last);
   end

   // Watchdog: end the run if the block stops making progress.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // Receiver: stall on a pattern that changes mode every so often, and
   // honor a long hold-off when the stimulus asks for one.
   initial begin : rsp_stall
      int mode;
      int mode_left;
      int period;
      int duty;
      int phase;
      rsp_chan.ready = 1'b0;
      mode      = 0;
      mode_left = 0;
      period    = 1;
      duty      = 1;
      phase     = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_cycles > 0) begin
            // drop ready and count the hold here so the sender keeps going
            rsp_chan.ready <= 1'b0;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(64, 256);
            period    = $urandom_range(2, 7);
            duty      = $urandom_range(1, period - 1);
            phase     = 0;
         end
         mode_left--;
         phase++;
         case (mode)
            0: rsp_chan.ready <= 1'b1;                          // no stalls
            1: rsp_chan.ready <= ($urandom_range(0, 9) < 7);    // light random stalls
            2: rsp_chan.ready <= ((phase % period) < duty);     // fixed duty cycle
            default: rsp_chan.ready <= ($urandom_range(0, 3) == 0); // heavy stalls
         endcase
         @(negedge clock);
      end
   end

   // Offer one value at the current falling edge and hold it until the
   // block takes it; return at the next falling edge.
   task automatic push_value(op_type op, logic [31:0] v);
      req_chan.valid <= 1'b1;
      req_chan.op    <= op;
      req_chan.value <= v;
      do @(posedge clock); while (!req_chan.ready);
      sb.predict_text(op, v);
      @(negedge clock);
   endtask

   // Send one value, then maybe close the burst with an idle gap.
   task automatic send_value(op_type op, logic [31:0] v);
      int gap;
      push_value(op, v);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 7);
         gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // Stop offering and wait until every owed character has arrived.
   task automatic drain_text();
      req_chan.valid <= 1'b0;
      while (sb.pending_count() > 0) @(negedge clock);
   endtask

   // Shape random values so short texts, long texts, sign flips and
   // digit-count boundaries all turn up often.
   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      int k;
      k = $urandom_range(0, 31);
      case ($urandom_range(0, 6))
         0: v = $urandom_range(0, 20);
         1: v = 32'd1 << k;
         2: v = (32'd1 << k) - 32'd1;
         3: v = -$urandom_range(1, 20);
         4: v = 32'h8000_0000 ^ $urandom_range(0, 3);
         default: v = $urandom;
      endcase
      return v;
   endfunction

   initial begin : stimulus
      op_type op;
      int n;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.op    = OP_BIN;
      req_chan.value = '0;

      // hold reset, then release it on a falling edge
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: zero and all ones in every format, then the corners of
      // sign handling, hex case and decimal digit counts.
      for (n = 0; n < 8; n++) begin
         op = op_type'(n);
         send_value(op, 32'h0000_0000);
         send_value(op, 32'hFFFF_FFFF);
      end
      send_value(OP_SDEC,     32'h8000_0000);  // most negative value
      send_value(OP_SDEC,     32'h7FFF_FFFF);
      send_value(OP_SDEC,     32'hFFFF_FFF6);  // -10
      send_value(OP_BIN,      32'h0000_0001);
      send_value(OP_BIN,      32'h8000_0000);
      send_value(OP_HEX_UC,   32'h0000_ABCD);
      send_value(OP_HEX_LC_P, 32'h0000_ABCD);
      send_value(OP_UDEC,     32'd1000000000);
      send_value(OP_UDEC,     32'd9);

      // pause until every character of the directed part has come back
      drain_text();
      @(negedge clock);

      for (n = 0; n < RAND_VALUES; n++) begin
         // switch pacing between phases, including stretches with no gaps
         if (n % 60 == 0)
            case ($urandom_range(0, 2))
               0: gap_max = 0;
               1: gap_max = 4;
               default: gap_max = 20;
            endcase
         if (n == 150) begin
            // long receiver hold-off while values keep coming back to back
            hold_cycles = LONG_HOLD;
            gap_max     = 0;
         end
         if (n == 320) begin
            drain_text();
            @(negedge clock);
         end
         op = op_type'($urandom_range(0, 7));
         send_value(op, pick_value());
      end

      drain_text();
      repeat (TAIL_CYCLES) @(negedge clock);

      if (sb.failures == 0 && sb.pending_count() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
